// ===== rtl/aidp_pkg.sv =====
// Shared types, character constants and character-class functions of the account ID parser.
package aidp_pkg;

    // Character constants.
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_X_UP   = 8'h58;
    localparam logic [7:0] CHAR_X_LOW  = 8'h78;

    // Lengths and positions that the formats depend on.
    localparam logic [4:0] COUNT_MAX    = 5'd31;
    localparam logic [4:0] B64_LEN      = 5'd12;
    localparam logic [4:0] B64_LAST_POS = 5'd10;
    localparam logic [4:0] HEX_DIGITS   = 5'd16;
    localparam logic [4:0] PREFIX_LEN   = 5'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_EMPTY        = 2'd1,
        ST_DEC_OVERFLOW = 2'd2,
        ST_BAD_FORM     = 2'd3
    } status_t;

    // Result format codes.
    typedef enum logic [1:0] {
        FMT_NONE    = 2'd0,
        FMT_BASE64  = 2'd1,
        FMT_DECIMAL = 2'd2,
        FMT_HEX     = 2'd3
    } format_t;

    // Decoded base64 and hex symbols.
    typedef struct packed {
        logic       ok;
        logic [5:0] code;
    } b64_sym_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] code;
    } hex_sym_t;

    // Running state of one text.
    typedef struct packed {
        logic [4:0]  char_count;
        logic        first_is_zero;
        logic        prefix_seen;
        logic [7:0]  prev_char;
        logic        b64_chars_ok;
        logic [63:0] b64_bits;
        logic        digits_only;
        logic [63:0] dec_value;
        logic        dec_overflow;
        logic [63:0] hex_value;
        logic [4:0]  hex_count_all;
        logic        hex_ok_all;
        logic [4:0]  hex_count_tail;
        logic        hex_ok_tail;
    } aidp_state_t;

    localparam aidp_state_t STATE_RESET = '{
        char_count:     5'd0,
        first_is_zero:  1'b0,
        prefix_seen:    1'b0,
        prev_char:      8'h00,
        b64_chars_ok:   1'b1,
        b64_bits:       64'd0,
        digits_only:    1'b1,
        dec_value:      64'd0,
        dec_overflow:   1'b0,
        hex_value:      64'd0,
        hex_count_all:  5'd0,
        hex_ok_all:     1'b1,
        hex_count_tail: 5'd0,
        hex_ok_tail:    1'b1
    };

    // Space, TAB, LF, VT, FF and CR are dropped.
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    // Base64 alphabet, with both the standard and the URL-safe symbols for 62 and 63.
    function automatic b64_sym_t b64_code(input logic [7:0] c);
        b64_sym_t s;
        s.ok = 1'b1;
        if (c inside {[8'h41:8'h5A]}) begin
            s.code = 6'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            s.code = 6'(c - 8'd71);
        end else if (c inside {[8'h30:8'h39]}) begin
            s.code = 6'(c + 8'd4);
        end else if (c inside {8'h2B, 8'h2D}) begin
            s.code = 6'd62;
        end else if (c inside {8'h2F, 8'h5F}) begin
            s.code = 6'd63;
        end else begin
            s.ok   = 1'b0;
            s.code = 6'd0;
        end
        return s;
    endfunction

    // Hex digit value, either case.
    function automatic hex_sym_t hex_code(input logic [7:0] c);
        hex_sym_t s;
        s.ok = 1'b1;
        if (c inside {[8'h30:8'h39]}) begin
            s.code = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            s.code = 4'(c - 8'd87);
        end else if (c inside {[8'h41:8'h46]}) begin
            s.code = 4'(c - 8'd55);
        end else begin
            s.ok   = 1'b0;
            s.code = 4'd0;
        end
        return s;
    endfunction

    // Counter increment that stops at its top value.
    function automatic logic [4:0] sat_inc(input logic [4:0] v);
        return (v == COUNT_MAX) ? v : v + 5'd1;
    endfunction

endpackage

// ===== rtl/aidp_scan.sv =====
// Per-character state update of the account ID parser: all three readings advance at once.
module aidp_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 has_char,
    input  logic [7:0]           text_char,
    input  logic                 last,
    output aidp_pkg::aidp_state_t post_state
);
    import aidp_pkg::*;

    aidp_state_t state_reg;
    aidp_state_t state_next;
    aidp_state_t upd;
    b64_sym_t    b64;
    hex_sym_t    hex;
    logic        take;
    logic        clear;
    logic        is_sep;
    logic        is_digit;
    logic [4:0]  pos;
    logic [67:0] dec_sum;

    assign take  = fire && has_char && !is_space(text_char);
    assign clear = fire && last;

    // Character classes and the decimal step (value * 10 + digit as shifts and two adds).
    always_comb
    begin
        b64      = b64_code(text_char);
        hex      = hex_code(text_char);
        is_sep   = (text_char == CHAR_COLON) || (text_char == CHAR_DASH);
        is_digit = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
        pos      = state_reg.char_count;
        dec_sum  = {1'b0, state_reg.dec_value, 3'b000}
                 + {3'b000, state_reg.dec_value, 1'b0}
                 + 68'(text_char - CHAR_ZERO);
    end

    // State after taking the current character.
    always_comb
    begin
        upd = state_reg;

        if (pos == 5'd0 && text_char == CHAR_ZERO) begin
            upd.first_is_zero = 1'b1;
        end
        if (pos == 5'd1 && state_reg.first_is_zero &&
            (text_char == CHAR_X_LOW || text_char == CHAR_X_UP)) begin
            upd.prefix_seen = 1'b1;
        end

        // Base64 collects 6 bits per character and 4 from the eleventh.
        if (pos <= B64_LAST_POS) begin
            if (!b64.ok) begin
                upd.b64_chars_ok = 1'b0;
            end else if (pos < B64_LAST_POS) begin
                upd.b64_bits = {state_reg.b64_bits[57:0], b64.code};
            end else begin
                upd.b64_bits = {state_reg.b64_bits[59:0], b64.code[5:2]};
            end
        end

        // Decimal overflow is sticky and freezes the value.
        if (!is_digit) begin
            upd.digits_only = 1'b0;
        end else if (!state_reg.dec_overflow) begin
            if (|dec_sum[67:64]) begin
                upd.dec_overflow = 1'b1;
            end else begin
                upd.dec_value = dec_sum[63:0];
            end
        end

        // Hex keeps the last sixteen digits; separators are not counted.
        if (hex.ok) begin
            upd.hex_value = {state_reg.hex_value[59:0], hex.code};
        end
        if (!is_sep) begin
            upd.hex_count_all = sat_inc(state_reg.hex_count_all);
            if (!hex.ok) begin
                upd.hex_ok_all = 1'b0;
            end
            if (pos >= PREFIX_LEN) begin
                upd.hex_count_tail = sat_inc(state_reg.hex_count_tail);
                if (!hex.ok) begin
                    upd.hex_ok_tail = 1'b0;
                end
            end
        end

        upd.prev_char  = text_char;
        upd.char_count = sat_inc(state_reg.char_count);
    end

    // The result sees the state including this word; the last word restarts the text.
    always_comb
    begin
        post_state = take ? upd : state_reg;
        state_next = clear ? STATE_RESET : post_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= STATE_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hex_count_tail <= state_reg.hex_count_all &&
        state_reg.hex_count_all <= state_reg.char_count)
        else $error("hex counts exceed the character count");

    a_prefix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.prefix_seen |-> state_reg.first_is_zero)
        else $error("prefix seen without a leading zero");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> state_reg.char_count == 5'd0 && state_reg.digits_only &&
                  !state_reg.dec_overflow && state_reg.b64_chars_ok)
        else $error("state not restarted after the last word");

endmodule

// ===== rtl/aidp_result.sv =====
// Format decision and output register of the account ID parser.
module aidp_result (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  emit,
    input  aidp_pkg::aidp_state_t post_state,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [63:0]           m_tdata,   // account_value[63:0]
    output logic [3:0]            m_tuser,   // status[1:0], format[3:2]
    output logic                  out_free
);
    import aidp_pkg::*;

    status_t     status_next;
    format_t     format_next;
    logic [63:0] value_next;
    logic [63:0] b64_swapped;
    logic        pre;
    status_t     status_reg;
    format_t     format_reg;
    logic [63:0] value_reg;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;

    // Base64 bytes are taken little-endian.
    always_comb
    begin
        for (int i = 0; i < 8; i++) begin
            b64_swapped[8*i +: 8] = post_state.b64_bits[56-8*i +: 8];
        end
    end

    // Forms in priority order: base64, decimal, hex.
    always_comb
    begin
        pre         = post_state.prefix_seen && (post_state.char_count > PREFIX_LEN);
        status_next = ST_BAD_FORM;
        format_next = FMT_NONE;
        value_next  = 64'd0;
        if (post_state.char_count == 5'd0) begin
            status_next = ST_EMPTY;
        end else if (!pre && post_state.char_count == B64_LEN &&
                     post_state.prev_char == CHAR_EQUAL && post_state.b64_chars_ok) begin
            status_next = ST_OK;
            format_next = FMT_BASE64;
            value_next  = b64_swapped;
        end else if (!pre && post_state.digits_only) begin
            if (post_state.dec_overflow) begin
                status_next = ST_DEC_OVERFLOW;
            end else begin
                status_next = ST_OK;
                format_next = FMT_DECIMAL;
                value_next  = post_state.dec_value;
            end
        end else if (pre ? (post_state.hex_count_tail == HEX_DIGITS && post_state.hex_ok_tail)
                         : (post_state.hex_count_all == HEX_DIGITS && post_state.hex_ok_all))
        begin
            status_next = ST_OK;
            format_next = FMT_HEX;
            value_next  = post_state.hex_value;
        end
    end

    // Output word handshake.
    assign out_free      = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            status_reg <= status_next;
            format_reg <= format_next;
            value_reg  <= value_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = {format_reg, status_reg};

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && status_reg != ST_OK |-> format_reg == FMT_NONE && value_reg == 64'd0)
        else $error("error result carries a format or value");

    a_ok_format: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && status_reg == ST_OK |-> format_reg != FMT_NONE)
        else $error("ok result without a format");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result written over a waiting word");

endmodule

// ===== rtl/account_id_text_parser.sv =====
// Top level of the account ID text parser: input register, state update and result register.
// The last input word goes through the input register and then the result register.
// Throughput: one input word per cycle; a result register parts input and output, so input
// stalls only when a last word meets a result word that is still waiting.
// Reset: rst_n clears the handshake registers and returns the parse state to an empty text.
module account_id_text_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_char[7:0]
    input  logic [0:0]  s_tuser,   // has_char[0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // account_value[63:0]
    output logic [3:0]  m_tuser    // status[1:0], format[3:2]
);
    import aidp_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_has_reg;
    logic        in_last_reg;
    logic        stage_fire;
    logic        out_free;
    logic        s_accept;
    aidp_state_t post_state;

    // A word leaves the input register unless it would produce a result into a full output.
    assign stage_fire    = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready      = !in_valid_reg || stage_fire;
    assign s_accept      = s_tvalid && s_tready;
    assign in_valid_next = s_accept ? 1'b1 : (stage_fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept) begin
            in_char_reg <= s_tdata;
            in_has_reg  <= s_tuser[0];
            in_last_reg <= s_tlast;
        end
    end

    // Running state of the three readings.
    aidp_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (stage_fire),
        .has_char   (in_has_reg),
        .text_char  (in_char_reg),
        .last       (in_last_reg),
        .post_state (post_state)
    );

    // Decision and output register.
    aidp_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (stage_fire && in_last_reg),
        .post_state (post_state),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .out_free   (out_free)
    );

endmodule
